/* hdl/tfj_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// tfj_pkg
// Shared constants and controller/datapath handshake types for the
// text full-justification block.
// ---------------------------------------------------------------------------
package tfj_pkg;

   localparam int MAX_WIDTH  = 32;
   localparam int MAX_WORDS  = (MAX_WIDTH + 1) / 2;
   localparam int CHAR_BITS  = 8;
   localparam int WIDTH_BITS = $clog2(MAX_WIDTH + 1);
   localparam int COUNT_BITS = $clog2(MAX_WORDS + 1);
   localparam int WIDX_BITS  = $clog2(MAX_WORDS);
   localparam int BUF_DEPTH  = 2 * MAX_WIDTH;
   localparam int PTR_BITS   = $clog2(BUF_DEPTH);
   localparam int QUOT_BITS  = WIDTH_BITS - 1;
   localparam int DVSR_BITS  = WIDX_BITS;

   localparam logic [CHAR_BITS-1:0]  SPACE_CHAR  = 8'h20;
   localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(MAX_WIDTH);

   typedef struct packed {
      logic take;
      logic plan_justify;
      logic plan_left;
      logic len_read;
      logic load_word;
      logic letter_read;
      logic out_letter;
      logic out_space;
      logic finish_line;
      logic append;
   } dp_cmd_type;

   typedef struct packed {
      logic word_end;
      logic text_end;
      logic fit;
      logic justify;
      logic col_done;
      logic rem_zero;
      logic more_words;
      logic gap_zero;
      logic out_free;
      logic div_busy;
   } dp_status_type;

endpackage
`default_nettype wire

/* hdl/tfj_if.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// tfj_if
// Valid/ready channels for input characters and justified output characters.
// ---------------------------------------------------------------------------
interface tfj_req_if;
   import tfj_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] char_code;
   logic                 word_end;
   logic                 text_end;
   modport source (output valid, char_code, word_end, text_end, input ready);
   modport sink   (input valid, char_code, word_end, text_end, output ready);
endinterface

interface tfj_rsp_if;
   import tfj_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] out_char;
   logic                 end_of_line;
   logic                 last_of_run;
   modport source (output valid, out_char, end_of_line, last_of_run, input ready);
   modport sink   (input valid, out_char, end_of_line, last_of_run, output ready);
endinterface
`default_nettype wire

/* hdl/tfj_ram.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// tfj_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module tfj_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(Depth)-1:0] waddr,
   input  wire logic [Width-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(Depth)-1:0] raddr,
   output logic      [Width-1:0]         rdata
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end
endmodule
`default_nettype wire

/* hdl/tfj_div.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// tfj_div
// Restoring divider, one quotient bit per cycle, for the gap spacing.
// ---------------------------------------------------------------------------
module tfj_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [tfj_pkg::QUOT_BITS-1:0] dividend,
   input  wire logic [tfj_pkg::DVSR_BITS-1:0] divisor,
   output logic                               busy,
   output logic      [tfj_pkg::QUOT_BITS-1:0] quotient,
   output logic      [tfj_pkg::DVSR_BITS-1:0] remainder
);
   import tfj_pkg::*;

   localparam int CNT_BITS = $clog2(QUOT_BITS);

   logic                 busy_ff, busy_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [QUOT_BITS-1:0] dvd_ff, dvd_in;
   logic [DVSR_BITS-1:0] rem_ff, rem_in;
   logic [DVSR_BITS-1:0] dvsr_ff, dvsr_in;
   logic [DVSR_BITS:0]   trial;
   logic [DVSR_BITS:0]   diff;
   logic                 qbit;

   always_comb begin
      trial   = {rem_ff, dvd_ff[QUOT_BITS-1]};
      diff    = trial - {1'b0, dvsr_ff};
      qbit    = (trial >= {1'b0, dvsr_ff});
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         dvsr_in = divisor;
      end else if (busy_ff) begin
         // The quotient bits shift in where the dividend bits shift out.
         dvd_in = {dvd_ff[QUOT_BITS-2:0], qbit};
         rem_in = qbit ? diff[DVSR_BITS-1:0] : trial[DVSR_BITS-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(QUOT_BITS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
   end

   assign busy      = busy_ff;
   assign quotient  = dvd_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

/* hdl/tfj_datapath.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// tfj_datapath
// Character ring buffer, word length store, line bookkeeping, the column
// walk that lays out one line and the output register.
// ---------------------------------------------------------------------------
module tfj_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [tfj_pkg::WIDTH_BITS-1:0] csr_wdata,
   input  wire logic [tfj_pkg::CHAR_BITS-1:0]  char_code,
   input  wire logic                           word_end,
   input  wire logic                           text_end,
   input  wire tfj_pkg::dp_cmd_type            cmd,
   output tfj_pkg::dp_status_type              status,
   input  wire logic                           rsp_ready,
   output logic                                rsp_valid,
   output logic      [tfj_pkg::CHAR_BITS-1:0]  out_char,
   output logic                                end_of_line,
   output logic                                last_of_run
);
   import tfj_pkg::*;

   logic [WIDTH_BITS-1:0] width_ff;
   logic [PTR_BITS-1:0]   base_ff;
   logic [WIDTH_BITS-1:0] total_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic [WIDTH_BITS-1:0] wlen_ff;
   logic                  we_ff, te_ff, just_ff;
   logic [WIDTH_BITS-1:0] col_ff;
   logic [PTR_BITS-1:0]   src_ff;
   logic [COUNT_BITS-1:0] wi_ff;
   logic [WIDTH_BITS-1:0] rem_ff;
   logic [WIDTH_BITS-1:0] gap_ff;
   logic                  valid_ff;
   logic [CHAR_BITS-1:0]  char_ff;
   logic                  eol_ff, last_ff;

   logic [WIDTH_BITS-1:0] w;
   logic [WIDTH_BITS:0]   need;
   logic [WIDTH_BITS-1:0] spare;
   logic [COUNT_BITS-1:0] gaps;
   logic                  div_busy;
   logic [QUOT_BITS-1:0]  div_q;
   logic [DVSR_BITS-1:0]  div_r;
   logic [WIDTH_BITS-1:0] q_use;
   logic [COUNT_BITS-1:0] r_use;
   logic                  out_free;
   logic                  eol;
   logic [CHAR_BITS-1:0]  ram_rdata;
   logic [WIDTH_BITS-1:0] len_rdata;
   logic                  char_we;
   logic [PTR_BITS-1:0]   char_waddr;

   // A width of zero acts as one, anything past the maximum as the maximum.
   always_comb begin
      if (width_ff == '0) begin
         w = WIDTH_BITS'(1);
      end else if (width_ff > WIDTH_BITS'(MAX_WIDTH)) begin
         w = WIDTH_BITS'(MAX_WIDTH);
      end else begin
         w = width_ff;
      end
   end

   assign need       = {1'b0, total_ff} + (WIDTH_BITS+1)'(count_ff) + {1'b0, wlen_ff};
   assign spare      = w - total_ff;
   assign gaps       = count_ff - 1'b1;
   assign q_use      = just_ff ? WIDTH_BITS'(div_q) : WIDTH_BITS'(1);
   assign r_use      = just_ff ? COUNT_BITS'(div_r) : '0;
   assign out_free   = !valid_ff || rsp_ready;
   assign eol        = (col_ff == w - 1'b1);
   assign char_we    = cmd.take && (wlen_ff < w);
   // The current word sits in the ring right after the buffered line.
   assign char_waddr = base_ff + PTR_BITS'(total_ff) + PTR_BITS'(wlen_ff);

   tfj_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.plan_justify),
      .dividend  (spare[QUOT_BITS-1:0]),
      .divisor   (gaps[DVSR_BITS-1:0]),
      .busy      (div_busy),
      .quotient  (div_q),
      .remainder (div_r)
   );

   tfj_ram #(.Width(CHAR_BITS), .Depth(BUF_DEPTH)) u_char_ram (
      .clock (clock),
      .we    (char_we),
      .waddr (char_waddr),
      .wdata (char_code),
      .re    (cmd.letter_read),
      .raddr (src_ff),
      .rdata (ram_rdata)
   );

   tfj_ram #(.Width(WIDTH_BITS), .Depth(MAX_WORDS)) u_len_ram (
      .clock (clock),
      .we    (cmd.append),
      .waddr (count_ff[WIDX_BITS-1:0]),
      .wdata (wlen_ff),
      .re    (cmd.len_read),
      .raddr (wi_ff[WIDX_BITS-1:0]),
      .rdata (len_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         base_ff  <= '0;
         total_ff <= '0;
         count_ff <= '0;
         wlen_ff  <= '0;
         we_ff    <= 1'b0;
         te_ff    <= 1'b0;
         just_ff  <= 1'b0;
         col_ff   <= '0;
         src_ff   <= '0;
         wi_ff    <= '0;
         rem_ff   <= '0;
         gap_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            width_ff <= csr_wdata;
            total_ff <= '0;
            count_ff <= '0;
            wlen_ff  <= '0;
         end
         if (cmd.take) begin
            we_ff <= word_end;
            te_ff <= text_end;
            if (char_we) begin
               wlen_ff <= wlen_ff + 1'b1;
            end
         end
         if (cmd.plan_justify || cmd.plan_left) begin
            just_ff <= cmd.plan_justify;
            col_ff  <= '0;
            src_ff  <= base_ff;
            wi_ff   <= '0;
            rem_ff  <= '0;
         end
         if (cmd.load_word) begin
            rem_ff <= len_rdata;
            gap_ff <= q_use + WIDTH_BITS'(wi_ff < r_use);
            wi_ff  <= wi_ff + 1'b1;
         end
         if (cmd.out_letter) begin
            col_ff <= col_ff + 1'b1;
            src_ff <= src_ff + 1'b1;
            rem_ff <= rem_ff - 1'b1;
         end
         if (cmd.out_space) begin
            col_ff <= col_ff + 1'b1;
            if (gap_ff != '0 && wi_ff < count_ff) begin
               gap_ff <= gap_ff - 1'b1;
            end
         end
         if (cmd.finish_line) begin
            base_ff  <= base_ff + PTR_BITS'(total_ff);
            total_ff <= '0;
            count_ff <= '0;
         end
         if (cmd.append) begin
            total_ff <= total_ff + wlen_ff;
            count_ff <= count_ff + 1'b1;
            wlen_ff  <= '0;
         end
         if (cmd.out_letter || cmd.out_space) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
      if (cmd.out_letter || cmd.out_space) begin
         char_ff <= cmd.out_letter ? ram_rdata : SPACE_CHAR;
         eol_ff  <= eol;
         // A justified line is followed by the last line when the text ends.
         last_ff <= eol && !(just_ff && te_ff);
      end
   end

   always_comb begin
      status.word_end   = we_ff;
      status.text_end   = te_ff;
      status.fit        = (count_ff == '0) || (need <= {1'b0, w});
      status.justify    = just_ff;
      status.col_done   = (col_ff == w);
      status.rem_zero   = (rem_ff == '0);
      status.more_words = (wi_ff < count_ff);
      status.gap_zero   = (gap_ff == '0);
      status.out_free   = out_free;
      status.div_busy   = div_busy;
   end

   assign rsp_valid   = valid_ff;
   assign out_char    = char_ff;
   assign end_of_line = eol_ff;
   assign last_of_run = last_ff;
endmodule
`default_nettype wire

/* hdl/tfj_ctrl.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// tfj_ctrl
// Sequencer: takes characters, decides line breaks and steps the datapath
// through the layout of each emitted line.
// ---------------------------------------------------------------------------
module tfj_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire tfj_pkg::dp_status_type status,
   output tfj_pkg::dp_cmd_type         cmd
);
   import tfj_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CHECK  = 4'd1;
   localparam logic [3:0] S_DIV    = 4'd2;
   localparam logic [3:0] S_LW     = 4'd3;
   localparam logic [3:0] S_GW     = 4'd4;
   localparam logic [3:0] S_CH     = 4'd5;
   localparam logic [3:0] S_OL     = 4'd6;
   localparam logic [3:0] S_OS     = 4'd7;
   localparam logic [3:0] S_APPEND = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!status.word_end) begin
               state_in = S_IDLE;
            end else if (!status.fit) begin
               cmd.plan_justify = 1'b1;
               state_in         = S_DIV;
            end else begin
               state_in = S_APPEND;
            end
         end
         S_DIV: begin
            if (!status.div_busy) begin
               state_in = S_LW;
            end
         end
         S_LW: begin
            cmd.len_read = 1'b1;
            state_in     = S_GW;
         end
         S_GW: begin
            cmd.load_word = 1'b1;
            state_in      = S_CH;
         end
         S_CH: begin
            if (status.col_done) begin
               cmd.finish_line = 1'b1;
               state_in        = status.justify ? S_APPEND : S_IDLE;
            end else if (!status.rem_zero) begin
               cmd.letter_read = 1'b1;
               state_in        = S_OL;
            end else if (status.more_words) begin
               state_in = status.gap_zero ? S_LW : S_OS;
            end else begin
               state_in = S_OS;
            end
         end
         S_OL: begin
            if (status.out_free) begin
               cmd.out_letter = 1'b1;
               state_in       = S_CH;
            end
         end
         S_OS: begin
            if (status.out_free) begin
               cmd.out_space = 1'b1;
               state_in      = S_CH;
            end
         end
         S_APPEND: begin
            cmd.append = 1'b1;
            if (status.text_end) begin
               cmd.plan_left = 1'b1;
               state_in      = S_LW;
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

/* hdl/text_full_justify.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// text_full_justify
// Greedy full justification of a character stream into fixed-width lines.
// ---------------------------------------------------------------------------
// Characters are taken one per transfer, none before the last is handled; a
// character that ends no line produces no output. When a finished word does
// not fit the buffered line, that line is sent fully justified, and at the end
// of the text the last line is sent left-justified, each line as exactly
// line_width transfers. For each output letter the sequencer reads the
// character buffer and then loads the output register, and each word's
// length is fetched before its letters; a justified line also waits for
// the bit-serial gap divider. Output stalls hold the sequencer; the last
// finished character waits in the output register. Writing csr_wdata
// discards the buffered line and current word.
module text_full_justify (
   input  wire logic                           clock,
   input  wire logic                           reset,
   tfj_req_if.sink                             req_bus,
   tfj_rsp_if.source                           rsp_bus,
   input  wire logic                           csr_we,
   input  wire logic [tfj_pkg::WIDTH_BITS-1:0] csr_wdata
);
   import tfj_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_ready;

   assign req_bus.ready = req_ready;

   tfj_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tfj_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .char_code   (req_bus.char_code),
      .word_end    (req_bus.word_end),
      .text_end    (req_bus.text_end),
      .cmd         (cmd),
      .status      (status),
      .rsp_ready   (rsp_bus.ready),
      .rsp_valid   (rsp_bus.valid),
      .out_char    (rsp_bus.out_char),
      .end_of_line (rsp_bus.end_of_line),
      .last_of_run (rsp_bus.last_of_run)
   );

   // An output character is only loaded when the output register can take it.
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_letter || cmd.out_space) |-> status.out_free)
      else $error("output loaded while register full");

   // A line never grows past the configured width.
   a_line_bound: assert property (@(posedge clock) disable iff (reset)
      status.col_done |-> !(cmd.out_letter || cmd.out_space))
      else $error("character emitted past line width");

   // Taking a character, planning a line and closing a line are exclusive.
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.take, cmd.plan_justify, cmd.plan_left, cmd.finish_line}))
      else $error("conflicting sequencer commands");

   // The column walk starts only after the divider has settled the gaps.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      cmd.load_word |-> !status.div_busy)
      else $error("word loaded while divider busy");
endmodule
`default_nettype wire
